// File: rtl/wsfe_pkg.sv
`default_nettype none

package wsfe_pkg;

    localparam logic       CMD_START      = 1'b0;
    localparam logic       CMD_DATA       = 1'b1;

    localparam logic [63:0] LEN_DIRECT_MAX = 64'd125;
    localparam logic [63:0] LEN_16_MAX     = 64'd65535;
    localparam logic [6:0]  LEN_CODE_16    = 7'd126;
    localparam logic [6:0]  LEN_CODE_64    = 7'd127;

    localparam logic [3:0]  EXT_BYTES_16   = 4'd2;
    localparam logic [3:0]  EXT_BYTES_64   = 4'd8;
    localparam logic [3:0]  KEY_BYTES      = 4'd4;
    localparam logic [3:0]  BASE_BYTES     = 4'd2;

    typedef enum logic [1:0] {
        LK_DIRECT,
        LK_16,
        LK_64
    } t_len_kind;

    typedef struct packed {
        logic        fin;
        logic        rsv1;
        logic        rsv2;
        logic        rsv3;
        logic [3:0]  opcode;
        logic        mask_enable;
        logic [31:0] mask_key;
        logic [63:0] payload_length;
        t_len_kind   len_kind;
    } t_hdr;

    typedef struct packed {
        logic load;
        logic step;
    } t_mask_ctl;

endpackage

`default_nettype wire

// File: rtl/wsfe_hdr_sel.sv
`default_nettype none

module wsfe_hdr_sel (
    input  wsfe_pkg::t_hdr i_hdr,
    input  logic [3:0]     i_idx,
    output logic [7:0]     o_byte,
    output logic           o_last
);
    import wsfe_pkg::*;

    logic [3:0] ext_bytes;
    logic [3:0] total;
    logic [3:0] len_pos;
    logic [3:0] key_pos;
    logic [2:0] len_sel;
    logic [1:0] key_sel;
    logic [6:0] len_code;

    always_comb begin
        case (i_hdr.len_kind)
            LK_DIRECT: begin
                ext_bytes = 4'd0;
                len_code  = i_hdr.payload_length[6:0];
            end
            LK_16: begin
                ext_bytes = EXT_BYTES_16;
                len_code  = LEN_CODE_16;
            end
            LK_64: begin
                ext_bytes = EXT_BYTES_64;
                len_code  = LEN_CODE_64;
            end
            default: begin
                ext_bytes = 4'd0;
                len_code  = i_hdr.payload_length[6:0];
            end
        endcase

        total   = BASE_BYTES + ext_bytes + (i_hdr.mask_enable ? KEY_BYTES : 4'd0);
        len_pos = i_idx - BASE_BYTES;
        key_pos = i_idx - BASE_BYTES - ext_bytes;
        len_sel = (ext_bytes[2:0] - 3'd1) - len_pos[2:0];
        key_sel = 2'd3 - key_pos[1:0];

        if (i_idx == 4'd0) begin
            o_byte = {i_hdr.fin, i_hdr.rsv1, i_hdr.rsv2, i_hdr.rsv3, i_hdr.opcode};
        end else if (i_idx == 4'd1) begin
            o_byte = {i_hdr.mask_enable, len_code};
        end else if (len_pos < ext_bytes) begin
            o_byte = i_hdr.payload_length[len_sel*8 +: 8];
        end else begin
            o_byte = i_hdr.mask_key[key_sel*8 +: 8];
        end

        o_last = (i_idx == total - 4'd1);
    end

endmodule

`default_nettype wire

// File: rtl/wsfe_mask_unit.sv
`default_nettype none

module wsfe_mask_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wsfe_pkg::t_mask_ctl i_ctl,
    input  logic                i_mask_enable,
    input  logic [31:0]         i_mask_key,
    input  logic [7:0]          i_data_byte,
    output logic [7:0]          o_data_byte
);
    import wsfe_pkg::*;

    logic        r_masking_on;
    logic [31:0] r_key_store;
    logic [1:0]  r_key_pos;
    logic        n_masking_on;
    logic [31:0] n_key_store;
    logic [1:0]  n_key_pos;
    logic [1:0]  key_sel;

    always_comb begin
        n_masking_on = r_masking_on;
        n_key_store  = r_key_store;
        n_key_pos    = r_key_pos;
        if (i_ctl.load) begin
            n_masking_on = i_mask_enable;
            n_key_store  = i_mask_key;
            n_key_pos    = 2'd0;
        end else if (i_ctl.step) begin
            n_key_pos = r_key_pos + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_masking_on <= 1'b0;
            r_key_store  <= '0;
            r_key_pos    <= '0;
        end else begin
            r_masking_on <= n_masking_on;
            r_key_store  <= n_key_store;
            r_key_pos    <= n_key_pos;
        end
    end

    assign key_sel     = 2'd3 - r_key_pos;
    assign o_data_byte = r_masking_on ? (i_data_byte ^ r_key_store[key_sel*8 +: 8])
                                      : i_data_byte;

endmodule

`default_nettype wire

// File: rtl/websocket_frame_encoder_unit.sv
`default_nettype none

// WebSocket (RFC 6455) frame encoder, sending side. A start transaction
// (cmd 0) is held in the input register and its header goes out one byte
// per cycle unless stalled: 2 bytes, plus 0, 2 or 8 extended length bytes,
// plus 4 key bytes when masking is on, so 2 to 14 bytes. A payload
// transaction (cmd 1) leaves as a single byte, XORed with the running key
// byte when the last start enabled masking, so payload streams at one
// byte per cycle unless stalled. The byte counter of the header
// serializer sets the rate of start transactions. Output bytes pass
// through a result register; run_last marks the final byte of each input
// transaction. Payload count is not checked against the header length.
module websocket_frame_encoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic        i_fin,
    input  logic        i_rsv1,
    input  logic        i_rsv2,
    input  logic        i_rsv3,
    input  logic [3:0]  i_opcode,
    input  logic        i_mask_enable,
    input  logic [31:0] i_mask_key,
    input  logic [63:0] i_payload_length,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_run_last
);
    import wsfe_pkg::*;

    logic       r_a_valid;
    logic       r_cmd;
    t_hdr       r_hdr;
    logic [7:0] r_data;
    logic [3:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    t_hdr       n_hdr;
    t_mask_ctl  mask_ctl;
    logic [7:0] hdr_byte;
    logic       hdr_last;
    logic [7:0] masked_byte;
    logic       out_load;
    logic       a_fire;
    logic       a_last;
    logic [7:0] a_byte;
    logic       in_acc;

    always_comb begin
        n_hdr.fin            = i_fin;
        n_hdr.rsv1           = i_rsv1;
        n_hdr.rsv2           = i_rsv2;
        n_hdr.rsv3           = i_rsv3;
        n_hdr.opcode         = i_opcode;
        n_hdr.mask_enable    = i_mask_enable;
        n_hdr.mask_key       = i_mask_key;
        n_hdr.payload_length = i_payload_length;
        if (i_payload_length <= LEN_DIRECT_MAX) begin
            n_hdr.len_kind = LK_DIRECT;
        end else if (i_payload_length <= LEN_16_MAX) begin
            n_hdr.len_kind = LK_16;
        end else begin
            n_hdr.len_kind = LK_64;
        end
    end

    wsfe_hdr_sel u_hdr_sel (
        .i_hdr  (r_hdr),
        .i_idx  (r_idx),
        .o_byte (hdr_byte),
        .o_last (hdr_last)
    );

    wsfe_mask_unit u_mask (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (mask_ctl),
        .i_mask_enable (r_hdr.mask_enable),
        .i_mask_key    (r_hdr.mask_key),
        .i_data_byte   (r_data),
        .o_data_byte   (masked_byte)
    );

    assign out_load      = !r_out_valid || !i_out_stall;
    assign a_fire        = r_a_valid && out_load;
    assign a_last        = (r_cmd == CMD_DATA) ? 1'b1 : hdr_last;
    assign a_byte        = (r_cmd == CMD_DATA) ? masked_byte : hdr_byte;
    assign mask_ctl.load = a_fire && (r_cmd == CMD_START) && (r_idx == 4'd0);
    assign mask_ctl.step = a_fire && (r_cmd == CMD_DATA);
    assign o_in_stall    = r_a_valid && !(a_fire && a_last);
    assign in_acc        = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_a_valid <= 1'b1;
            end else if (a_fire && a_last) begin
                r_a_valid <= 1'b0;
            end
            if (a_fire) begin
                r_idx <= a_last ? 4'd0 : r_idx + 4'd1;
            end
            if (out_load) begin
                r_out_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd  <= i_cmd;
            r_hdr  <= n_hdr;
            r_data <= i_data_byte;
        end
        if (a_fire) begin
            r_out_byte <= a_byte;
            r_out_last <= a_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_run_last  = r_out_last;

endmodule

`default_nettype wire

// File: rtl/wsfe_chk.sv
`default_nettype none

module wsfe_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_out_byte,
    input logic       o_run_last
);

    // stalled output transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_out_byte) && $stable(o_run_last))
        else $error("output changed while stalled");

    // reset empties the block
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not empty after reset");

    // held item with free output must produce a byte
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall && !o_out_valid |=> o_out_valid)
        else $error("held item did not move to output");

    // header bytes leave back to back
    a_hdr_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_run_last && !i_out_stall |=> o_out_valid)
        else $error("gap inside a multi byte transaction");

endmodule

bind websocket_frame_encoder_unit wsfe_chk u_wsfe_chk (.*);

`default_nettype wire
